### rtl/core/tdssm_pkg.sv
// Shared types, constants and segment decoding for the three-digit display driver.
package tdssm_pkg;

  typedef logic [1:0]  opcode_t;
  typedef logic [7:0]  value_t;
  typedef logic [1:0]  blink_t;
  typedef logic [7:0]  segments_t;
  typedef logic [2:0]  enable_t;
  typedef logic [4:0]  code_t;
  typedef logic [10:0] count_t;
  typedef logic [1:0]  index_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_SHOW  = 2'd1;
  localparam opcode_t OP_BLINK = 2'd2;

  localparam blink_t BLINK_STEADY = 2'd0;
  localparam blink_t BLINK_SLOW   = 2'd1;
  localparam blink_t BLINK_FAST   = 2'd2;

  localparam value_t DASH_CHAR = 8'd45;
  localparam code_t  DASH_CODE = 5'd16;

  localparam count_t SLOW_PERIOD = 11'd1200;
  localparam count_t SLOW_LIT    = 11'd600;
  localparam count_t FAST_PERIOD = 11'd600;
  localparam count_t FAST_LIT    = 11'd300;

  localparam segments_t SEG_RESET = 8'd253;

  function automatic segments_t seg_pattern(input code_t code);
    segments_t pat;
    unique case (code)
      5'd0:    pat = 8'h3F;
      5'd1:    pat = 8'h06;
      5'd2:    pat = 8'h5B;
      5'd3:    pat = 8'h4F;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'h6D;
      5'd6:    pat = 8'h7D;
      5'd7:    pat = 8'h07;
      5'd8:    pat = 8'h7F;
      5'd9:    pat = 8'h67;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h7C;
      5'd12:   pat = 8'h39;
      5'd13:   pat = 8'h5E;
      5'd14:   pat = 8'h79;
      5'd15:   pat = 8'h71;
      5'd16:   pat = 8'h40;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

### rtl/core/three_digit_seven_segment_mux_core.sv
// Multiplexed three-digit seven-segment display driver with blink control.
// Latency: the result word for an accepted input word is valid in the next cycle.
// Throughput: one word per cycle while out_ready is high; the display latches double as the output register.
// Reset (synchronous, active low): steady mode, digit index 0, blink count 0,
// all digits dash, segments 253, enables off, no result pending.
module three_digit_seven_segment_mux_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tdssm_pkg::opcode_t    in_opcode,
  input  tdssm_pkg::value_t     in_value,
  input  tdssm_pkg::blink_t     in_blink_request,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tdssm_pkg::segments_t  out_segments_n,
  output tdssm_pkg::enable_t    out_digit_enable
);
  import tdssm_pkg::*;

  logic      out_valid_r;
  index_t    digit_index_r, digit_index_nxt;
  count_t    blink_count_r, blink_count_nxt;
  blink_t    blink_mode_r, blink_mode_nxt;
  code_t     hundreds_r, hundreds_nxt;
  code_t     tens_r, tens_nxt;
  code_t     units_r, units_nxt;
  segments_t seg_latch_r, seg_latch_nxt;
  enable_t   en_latch_r, en_latch_nxt;

  logic      accept;
  index_t    idx;
  code_t     cur_code;
  enable_t   cur_en;
  count_t    period, lit, cnt_base;
  logic [1:0]  h_digit;
  logic [6:0]  rest;
  logic [14:0] tens_prod;
  logic [3:0]  t_digit;
  logic [6:0]  t_times10;

  assign in_ready         = !out_valid_r || out_ready;
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_segments_n   = seg_latch_r;
  assign out_digit_enable = en_latch_r;

  always_comb begin
    idx = (digit_index_r == 2'd3) ? 2'd0 : digit_index_r;
    unique case (idx)
      2'd0: begin
        cur_code = hundreds_r;
        cur_en   = 3'b001;
      end
      2'd1: begin
        cur_code = tens_r;
        cur_en   = 3'b010;
      end
      default: begin
        cur_code = units_r;
        cur_en   = 3'b100;
      end
    endcase

    period   = (blink_mode_r == BLINK_SLOW) ? SLOW_PERIOD : FAST_PERIOD;
    lit      = (blink_mode_r == BLINK_SLOW) ? SLOW_LIT : FAST_LIT;
    cnt_base = (blink_count_r >= period) ? 11'd0 : blink_count_r;

    if (in_value >= 8'd200) begin
      h_digit = 2'd2;
      rest    = 7'(in_value - 8'd200);
    end else if (in_value >= 8'd100) begin
      h_digit = 2'd1;
      rest    = 7'(in_value - 8'd100);
    end else begin
      h_digit = 2'd0;
      rest    = in_value[6:0];
    end
    tens_prod = 15'(rest) * 15'd205;
    t_digit   = tens_prod[14:11];
    t_times10 = 7'({t_digit, 3'b000} + {t_digit, 1'b0});

    digit_index_nxt = digit_index_r;
    blink_count_nxt = blink_count_r;
    blink_mode_nxt  = blink_mode_r;
    hundreds_nxt    = hundreds_r;
    tens_nxt        = tens_r;
    units_nxt       = units_r;
    seg_latch_nxt   = seg_latch_r;
    en_latch_nxt    = en_latch_r;

    unique case (in_opcode)
      OP_TICK: begin
        digit_index_nxt = idx + 2'd1;
        unique case (blink_mode_r)
          BLINK_STEADY: begin
            blink_count_nxt = '0;
            seg_latch_nxt   = ~seg_pattern(cur_code);
            en_latch_nxt    = cur_en;
          end
          BLINK_SLOW, BLINK_FAST: begin
            if (cnt_base < lit) begin
              seg_latch_nxt = ~seg_pattern(cur_code);
              en_latch_nxt  = cur_en;
            end else begin
              en_latch_nxt = '0;
            end
            blink_count_nxt = cnt_base + 11'd1;
          end
          default: begin
          end
        endcase
      end
      OP_SHOW: begin
        if (in_value == DASH_CHAR) begin
          hundreds_nxt   = DASH_CODE;
          tens_nxt       = DASH_CODE;
          units_nxt      = DASH_CODE;
          blink_mode_nxt = BLINK_STEADY;
        end else begin
          hundreds_nxt = 5'(h_digit);
          tens_nxt     = 5'(t_digit);
          units_nxt    = 5'(rest - t_times10);
        end
      end
      OP_BLINK: begin
        blink_mode_nxt = in_blink_request;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      digit_index_r <= '0;
      blink_count_r <= '0;
      blink_mode_r  <= BLINK_STEADY;
      hundreds_r    <= DASH_CODE;
      tens_r        <= DASH_CODE;
      units_r       <= DASH_CODE;
      seg_latch_r   <= SEG_RESET;
      en_latch_r    <= '0;
    end else begin
      if (accept) begin
        out_valid_r   <= 1'b1;
        digit_index_r <= digit_index_nxt;
        blink_count_r <= blink_count_nxt;
        blink_mode_r  <= blink_mode_nxt;
        hundreds_r    <= hundreds_nxt;
        tens_r        <= tens_nxt;
        units_r       <= units_nxt;
        seg_latch_r   <= seg_latch_nxt;
        en_latch_r    <= en_latch_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### tb/tb_three_digit_seven_segment_mux_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-digit multiplexed seven-segment display driver.
module tb_three_digit_seven_segment_mux_core;
  import tdssm_pkg::*;

  localparam opcode_t OP_UNUSED    = 2'd3;
  localparam blink_t  BLINK_FROZEN = 2'd3;
  localparam int      STALL_LIMIT  = 4000;
  localparam int      PRINT_LIMIT  = 50;
  localparam logic [17*8-1:0] GLYPHS = {
    8'h40, 8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h67, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    segments_t seg_n;
    enable_t   en;
  } display_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  opcode_t   in_opcode = OP_TICK;
  value_t    in_value = '0;
  blink_t    in_blink_request = BLINK_STEADY;
  logic      out_valid;
  logic      out_ready = 1'b0;
  segments_t out_segments_n;
  enable_t   out_digit_enable;

  index_t    scan_idx = '0;
  count_t    blink_ticks = '0;
  blink_t    blink_sel = BLINK_STEADY;
  code_t     digit_code [3] = '{DASH_CODE, DASH_CODE, DASH_CODE};
  segments_t seg_latch = SEG_RESET;
  enable_t   en_latch = '0;
  display_t  pending_display_q [$];

  int tx_idle_pct = 33;
  int rx_idle_pct = 71;
  int hold_token = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int dark_ticks = 0;
  int shows_sent = 0;
  int blink_cmds = 0;
  int ignored_sent = 0;

  three_digit_seven_segment_mux_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_blink_request (in_blink_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments_n   (out_segments_n),
    .out_digit_enable (out_digit_enable)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic light_digit();
    code_t c;
    case (scan_idx)
      2'd0: begin
        c = digit_code[0];
        en_latch = 3'b001;
      end
      2'd1: begin
        c = digit_code[1];
        en_latch = 3'b010;
      end
      default: begin
        c = digit_code[2];
        en_latch = 3'b100;
      end
    endcase
    seg_latch = (c <= DASH_CODE) ? ~GLYPHS[int'(c) * 8 +: 8] : 8'hFF;
  endtask

  task automatic blink_step(count_t period, count_t lit);
    if (blink_ticks >= period) blink_ticks = '0;
    if (blink_ticks < lit) light_digit();
    else en_latch = '0;
    blink_ticks = blink_ticks + 1'b1;
  endtask

  task automatic predict_display(opcode_t op, value_t val, blink_t req);
    int rest;
    display_t d;
    case (op)
      OP_TICK: begin
        ticks_sent++;
        if (scan_idx == 2'd3) scan_idx = 2'd0;
        case (blink_sel)
          BLINK_STEADY: begin
            blink_ticks = '0;
            light_digit();
          end
          BLINK_SLOW: blink_step(SLOW_PERIOD, SLOW_LIT);
          BLINK_FAST: blink_step(FAST_PERIOD, FAST_LIT);
          default: ;
        endcase
        scan_idx = scan_idx + 1'b1;
        if (en_latch == '0) dark_ticks++;
      end
      OP_SHOW: begin
        shows_sent++;
        if (val == DASH_CHAR) begin
          digit_code = '{DASH_CODE, DASH_CODE, DASH_CODE};
          blink_sel = BLINK_STEADY;
        end else begin
          rest = int'(val) % 100;
          digit_code[0] = code_t'(int'(val) / 100);
          digit_code[1] = code_t'(rest / 10);
          digit_code[2] = code_t'(rest % 10);
        end
      end
      OP_BLINK: begin
        blink_cmds++;
        blink_sel = req;
      end
      default: ignored_sent++;
    endcase
    d.seg_n = seg_latch;
    d.en = en_latch;
    pending_display_q.push_back(d);
  endtask

  task automatic send_word(opcode_t op, value_t val, blink_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= val;
    in_blink_request <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    predict_display(op, val, req);
  endtask

  task automatic send_ticks(int n, int show_pct);
    int r;
    value_t v;
    repeat (n) begin
      r = $urandom_range(0, 99);
      v = value_t'($urandom_range(0, 255));
      if (r < show_pct) begin
        if (v == DASH_CHAR) v = v + 1'b1;
        send_word(OP_SHOW, v, blink_t'($urandom_range(0, 3)));
      end else if (r < show_pct + 1) begin
        send_word(OP_UNUSED, v, blink_t'($urandom_range(0, 3)));
      end else begin
        send_word(OP_TICK, v, blink_t'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_display_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_view();
    send_word(OP_UNUSED, 8'hFF, BLINK_FROZEN);
    repeat (4) send_word(OP_TICK, 8'h00, BLINK_STEADY);
  endtask

  task automatic test_show_split();
    send_word(OP_SHOW, 8'd0, BLINK_STEADY);
    repeat (3) send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_SHOW, 8'd255, BLINK_FROZEN);
    repeat (3) send_word(OP_TICK, 8'hFF, BLINK_FROZEN);
    send_word(OP_SHOW, 8'd109, BLINK_STEADY);
    repeat (3) send_word(OP_TICK, 8'h55, BLINK_SLOW);
  endtask

  task automatic test_blink_directed();
    send_word(OP_BLINK, 8'hAA, BLINK_FAST);
    send_word(OP_SHOW, DASH_CHAR, BLINK_FAST);
    send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_FROZEN);
    send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_SLOW);
    send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_STEADY);
  endtask

  // The fast run crosses into its dark phase; the slow run then carries the
  // count through the slow dark phase and past the slow period.
  task automatic test_blink_periods();
    send_word(OP_BLINK, 8'h00, BLINK_STEADY);
    repeat (2) send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_FAST);
    repeat (305) send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_FROZEN);
    repeat (3) send_word(OP_TICK, 8'h00, BLINK_STEADY);
    send_word(OP_BLINK, 8'h00, BLINK_SLOW);
    repeat (900) send_word(OP_TICK, 8'h00, BLINK_STEADY);
  endtask

  task automatic test_random_traffic(int n_words);
    int stop_at;
    int r;
    value_t v;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      v = value_t'($urandom_range(0, 255));
      if (r < 55) begin
        send_word(OP_BLINK, v, blink_t'($urandom_range(0, 3)));
        send_ticks($urandom_range(1, 40), 8);
      end else if (r < 80) begin
        if ($urandom_range(0, 4) == 0) v = DASH_CHAR;
        send_word(OP_SHOW, v, blink_t'($urandom_range(0, 3)));
        send_ticks(3, 0);
      end else if (r < 90) begin
        send_word(OP_UNUSED, v, blink_t'($urandom_range(0, 3)));
      end else begin
        send_word(opcode_t'($urandom_range(0, 3)), v, blink_t'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_len <= 120;
    hold_token <= hold_token + 1;
    send_ticks(12, 20);
    pause_until_drained();
  endtask

  task automatic check_result();
    display_t want;
    results_checked++;
    if (pending_display_q.size() == 0) begin
      report_mismatch($sformatf("result seg=%h en=%b with no word outstanding",
                                out_segments_n, out_digit_enable));
    end else begin
      want = pending_display_q.pop_front();
      if (out_segments_n !== want.seg_n)
        report_mismatch($sformatf("segments_n got %h, want %h", out_segments_n, want.seg_n));
      if (out_digit_enable !== want.en)
        report_mismatch($sformatf("digit_enable got %b, want %b", out_digit_enable, want.en));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_view();
    test_show_split();
    test_blink_directed();
    test_random_traffic(100);
    test_backpressure();

    tx_idle_pct = 71;
    rx_idle_pct <= 33;
    test_random_traffic(100);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_blink_periods();
    test_random_traffic(100);

    pause_until_drained();
    repeat (4) @(posedge clk);

    $display("Run covered %0d words and %0d checked results: %0d refresh ticks (%0d blanked),",
             words_sent, results_checked, ticks_sent, dark_ticks);
    $display("%0d show words, %0d blink-mode words and %0d unused-opcode words; %0d mismatches.",
             shows_sent, blink_cmds, ignored_sent, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
